// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGB2YUV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RGB2YUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/rgb2yuv_pkg.sv =====
package rgb2yuv_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned COEF_W = 16;
    localparam int unsigned PROD_W = PIX_W + COEF_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned FRAC_W = 16;

    // BT.601 studio-range coefficients, scaled by 2^16
    localparam logic [COEF_W-1:0] KY_R = 16'd16829;
    localparam logic [COEF_W-1:0] KY_G = 16'd33039;
    localparam logic [COEF_W-1:0] KY_B = 16'd6416;
    localparam logic [COEF_W-1:0] KU_R = 16'd9714;
    localparam logic [COEF_W-1:0] KU_G = 16'd19071;
    localparam logic [COEF_W-1:0] KU_B = 16'd28784;
    localparam logic [COEF_W-1:0] KV_R = 16'd28784;
    localparam logic [COEF_W-1:0] KV_G = 16'd24103;
    localparam logic [COEF_W-1:0] KV_B = 16'd4681;

    localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [PIX_W-1:0] OUT_LOW       = 8'd16;
    localparam logic [PIX_W-1:0] OUT_HIGH      = 8'd240;

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
    } t_rgb_pair;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } t_yuv_word;

endpackage

// ===== sv/rgb2yuv_if.sv =====
interface rgb2yuv_pair_if;
    logic                   valid;
    logic                   ready;
    rgb2yuv_pkg::t_rgb_pair data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rgb2yuv_word_if;
    logic                   valid;
    logic                   ready;
    rgb2yuv_pkg::t_yuv_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rgb_pair_to_yuv422_converter.sv =====
// Channel   Dir   Payload                                Handshake
// i_pair    in    RGB888 pixel pair (first, second)      valid/ready
// o_word    out   YUV422 word Y0, U, Y1, V               valid/ready
//
// Four register stages: input + chroma pick, products, sums, round/clamp.
// One word per cycle when o_word.ready stays high.
// Each stage holds while the one after it is full and stalled, so nothing
// is dropped or repeated. Reset (i_rst_n, synchronous) clears the valid bits.
`include "assert_macros.svh"

module rgb_pair_to_yuv422_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgb2yuv_pair_if.sink          i_pair,
    rgb2yuv_word_if.source        o_word
);

    localparam int unsigned NSTG   = 4;
    localparam int unsigned PROD_W = rgb2yuv_pkg::PROD_W;
    localparam int unsigned SUM_W  = rgb2yuv_pkg::SUM_W;
    localparam int unsigned PIX_W  = rgb2yuv_pkg::PIX_W;
    localparam int unsigned RES_W  = 12;

    function automatic logic [PIX_W-1:0] finish_sample(
        input logic signed [SUM_W-1:0] s,
        input logic [PIX_W-1:0]        offset
    );
        logic [SUM_W-1:0]        mag;
        logic [SUM_W-1:0]        q;
        logic signed [RES_W-1:0] v;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        // round half away from zero on the magnitude
        q = (mag + (SUM_W'(1) << (rgb2yuv_pkg::FRAC_W - 1))) >> rgb2yuv_pkg::FRAC_W;
        v = s[SUM_W-1] ? -$signed(RES_W'(q)) : $signed(RES_W'(q));
        v = v + $signed(RES_W'(offset));
        if (v < $signed(RES_W'(rgb2yuv_pkg::OUT_LOW))) begin
            v = $signed(RES_W'(rgb2yuv_pkg::OUT_LOW));
        end
        if (v > $signed(RES_W'(rgb2yuv_pkg::OUT_HIGH))) begin
            v = $signed(RES_W'(rgb2yuv_pkg::OUT_HIGH));
        end
        return PIX_W'(v);
    endfunction

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] rdy;

    // stage 0: captured pair and chosen chroma pixel
    rgb2yuv_pkg::t_rgb_pair r_pair;
    logic [PIX_W-1:0]       r_cr, r_cg, r_cb;
    logic [PIX_W-1:0]       n_cr, n_cg, n_cb;

    // stage 1: products
    logic [PROD_W-1:0] r_y0r, r_y0g, r_y0b, r_y1r, r_y1g, r_y1b;
    logic [PROD_W-1:0] r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;

    // stage 2: sums
    logic signed [SUM_W-1:0] r_y0_sum, r_y1_sum, r_u_sum, r_v_sum;

    // stage 3: output word
    rgb2yuv_pkg::t_yuv_word r_word;
    logic                   word_in_range;

    always_comb begin
        rdy[NSTG-1] = !r_v[NSTG-1] || o_word.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign i_pair.ready = rdy[0];
    assign o_word.valid = r_v[NSTG-1];
    assign o_word.data  = r_word;

    // chroma from first pixel unless its red equals its green and the second's do not
    always_comb begin
        if (i_pair.data.red_first == i_pair.data.green_first
                && i_pair.data.red_second != i_pair.data.green_second) begin
            n_cr = i_pair.data.red_second;
            n_cg = i_pair.data.green_second;
            n_cb = i_pair.data.blue_second;
        end else begin
            n_cr = i_pair.data.red_first;
            n_cg = i_pair.data.green_first;
            n_cb = i_pair.data.blue_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_pair.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_pair <= i_pair.data;
            r_cr   <= n_cr;
            r_cg   <= n_cg;
            r_cb   <= n_cb;
        end
        if (rdy[1]) begin
            r_y0r <= PROD_W'(r_pair.red_first    * rgb2yuv_pkg::KY_R);
            r_y0g <= PROD_W'(r_pair.green_first  * rgb2yuv_pkg::KY_G);
            r_y0b <= PROD_W'(r_pair.blue_first   * rgb2yuv_pkg::KY_B);
            r_y1r <= PROD_W'(r_pair.red_second   * rgb2yuv_pkg::KY_R);
            r_y1g <= PROD_W'(r_pair.green_second * rgb2yuv_pkg::KY_G);
            r_y1b <= PROD_W'(r_pair.blue_second  * rgb2yuv_pkg::KY_B);
            r_ur  <= PROD_W'(r_cr * rgb2yuv_pkg::KU_R);
            r_ug  <= PROD_W'(r_cg * rgb2yuv_pkg::KU_G);
            r_ub  <= PROD_W'(r_cb * rgb2yuv_pkg::KU_B);
            r_vr  <= PROD_W'(r_cr * rgb2yuv_pkg::KV_R);
            r_vg  <= PROD_W'(r_cg * rgb2yuv_pkg::KV_G);
            r_vb  <= PROD_W'(r_cb * rgb2yuv_pkg::KV_B);
        end
        if (rdy[2]) begin
            r_y0_sum <= $signed(SUM_W'(r_y0r)) + $signed(SUM_W'(r_y0g))
                      + $signed(SUM_W'(r_y0b));
            r_y1_sum <= $signed(SUM_W'(r_y1r)) + $signed(SUM_W'(r_y1g))
                      + $signed(SUM_W'(r_y1b));
            r_u_sum  <= $signed(SUM_W'(r_ub)) - $signed(SUM_W'(r_ur))
                      - $signed(SUM_W'(r_ug));
            r_v_sum  <= $signed(SUM_W'(r_vr)) - $signed(SUM_W'(r_vg))
                      - $signed(SUM_W'(r_vb));
        end
        if (rdy[3]) begin
            r_word.luma_first  <= finish_sample(r_y0_sum, rgb2yuv_pkg::LUMA_OFFSET);
            r_word.chroma_blue <= finish_sample(r_u_sum, rgb2yuv_pkg::CHROMA_OFFSET);
            r_word.luma_second <= finish_sample(r_y1_sum, rgb2yuv_pkg::LUMA_OFFSET);
            r_word.chroma_red  <= finish_sample(r_v_sum, rgb2yuv_pkg::CHROMA_OFFSET);
        end
    end

    assign word_in_range = r_word.luma_first  >= rgb2yuv_pkg::OUT_LOW
                        && r_word.luma_first  <= rgb2yuv_pkg::OUT_HIGH
                        && r_word.chroma_blue >= rgb2yuv_pkg::OUT_LOW
                        && r_word.chroma_blue <= rgb2yuv_pkg::OUT_HIGH
                        && r_word.luma_second >= rgb2yuv_pkg::OUT_LOW
                        && r_word.luma_second <= rgb2yuv_pkg::OUT_HIGH
                        && r_word.chroma_red  >= rgb2yuv_pkg::OUT_LOW
                        && r_word.chroma_red  <= rgb2yuv_pkg::OUT_HIGH;

    `RGB2YUV_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_pair.valid && i_pair.ready, r_v[0])
    `RGB2YUV_ASSERT_NEXT(a_sum_hold, i_clk, i_rst_n, !rdy[2], $stable({r_v[2], r_y0_sum, r_u_sum}))
    `RGB2YUV_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_word.valid, word_in_range)

endmodule

// ===== verif/tb_rgb_pair_to_yuv422_converter.sv =====
`timescale 1ns / 100ps

module tb_rgb_pair_to_yuv422_converter;

    // Holds the YUV words still owed by the block and converts pixel pairs.
    class yuv_word_ledger;
        rgb2yuv_pkg::t_yuv_word owed_words[$];
        int unsigned            bad_words;

        function new();
            bad_words = 0;
        endfunction

        // Round from units of 2^-16, halves away from zero, add offset, clamp.
        function logic [rgb2yuv_pkg::PIX_W-1:0] settle(int sum, int offset);
            int v;
            if (sum >= 0) begin
                v = (sum + 32768) >>> 16;
            end else begin
                v = -((-sum + 32768) >>> 16);
            end
            v = v + offset;
            if (v < int'(rgb2yuv_pkg::OUT_LOW)) v = int'(rgb2yuv_pkg::OUT_LOW);
            if (v > int'(rgb2yuv_pkg::OUT_HIGH)) v = int'(rgb2yuv_pkg::OUT_HIGH);
            return v[rgb2yuv_pkg::PIX_W-1:0];
        endfunction

        function logic [rgb2yuv_pkg::PIX_W-1:0] luma_of(int r, int g, int b);
            return settle(int'(rgb2yuv_pkg::KY_R) * r + int'(rgb2yuv_pkg::KY_G) * g
                          + int'(rgb2yuv_pkg::KY_B) * b,
                          int'(rgb2yuv_pkg::LUMA_OFFSET));
        endfunction

        function rgb2yuv_pkg::t_yuv_word convert_pair(rgb2yuv_pkg::t_rgb_pair p);
            int                     r, g, b;
            rgb2yuv_pkg::t_yuv_word w;
            w.luma_first  = luma_of(int'(p.red_first), int'(p.green_first),
                                    int'(p.blue_first));
            w.luma_second = luma_of(int'(p.red_second), int'(p.green_second),
                                    int'(p.blue_second));
            // chroma source: second pixel when only the first has red equal to green, else first
            if (p.red_first == p.green_first && p.red_second != p.green_second) begin
                r = int'(p.red_second);
                g = int'(p.green_second);
                b = int'(p.blue_second);
            end else begin
                r = int'(p.red_first);
                g = int'(p.green_first);
                b = int'(p.blue_first);
            end
            w.chroma_blue = settle(-int'(rgb2yuv_pkg::KU_R) * r
                                   - int'(rgb2yuv_pkg::KU_G) * g
                                   + int'(rgb2yuv_pkg::KU_B) * b,
                                   int'(rgb2yuv_pkg::CHROMA_OFFSET));
            w.chroma_red  = settle(int'(rgb2yuv_pkg::KV_R) * r
                                   - int'(rgb2yuv_pkg::KV_G) * g
                                   - int'(rgb2yuv_pkg::KV_B) * b,
                                   int'(rgb2yuv_pkg::CHROMA_OFFSET));
            return w;
        endfunction

        function void note_pair(rgb2yuv_pkg::t_rgb_pair p);
            owed_words.push_back(convert_pair(p));
        endfunction

        function void compare_field(string field, logic [rgb2yuv_pkg::PIX_W-1:0] want,
                                    logic [rgb2yuv_pkg::PIX_W-1:0] got);
            if (want !== got) begin
                bad_words++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_word(rgb2yuv_pkg::t_yuv_word got);
            rgb2yuv_pkg::t_yuv_word want;
            if (owed_words.size() == 0) begin
                bad_words++;
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                return;
            end
            want = owed_words.pop_front();
            compare_field("luma_first", want.luma_first, got.luma_first);
            compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
            compare_field("luma_second", want.luma_second, got.luma_second);
            compare_field("chroma_red", want.chroma_red, got.chroma_red);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic steady_flow = 1'b0;

    rgb2yuv_pair_if pair_if ();
    rgb2yuv_word_if word_if ();

    yuv_word_ledger ledger = new();

    rgb_pair_to_yuv422_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_if),
        .o_word  (word_if)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Sink side: random back-pressure, none during the steady stretch.
    always @(negedge i_clk) begin
        word_if.ready <= steady_flow || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && word_if.valid && word_if.ready) begin
            ledger.check_word(word_if.data);
        end
    end

    function automatic rgb2yuv_pkg::t_rgb_pair make_pair(int r0, int g0, int b0,
                                                         int r1, int g1, int b1);
        rgb2yuv_pkg::t_rgb_pair p;
        p.red_first    = r0[7:0];
        p.green_first  = g0[7:0];
        p.blue_first   = b0[7:0];
        p.red_second   = r1[7:0];
        p.green_second = g1[7:0];
        p.blue_second  = b1[7:0];
        return p;
    endfunction

    function automatic rgb2yuv_pkg::t_rgb_pair random_pair();
        rgb2yuv_pkg::t_rgb_pair p;
        int                     kind;
        p    = 48'({$urandom, $urandom});
        kind = $urandom_range(9);
        case (kind)
            0, 1: begin
                p.green_first = p.red_first;
            end
            2, 3: begin
                p.green_second = p.red_second;
            end
            4: begin
                p.green_first  = p.red_first;
                p.green_second = p.red_second;
            end
            5: begin
                // full-scale corners
                p = make_pair($urandom_range(1) * 255, $urandom_range(1) * 255,
                              $urandom_range(1) * 255, $urandom_range(1) * 255,
                              $urandom_range(1) * 255, $urandom_range(1) * 255);
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Called and returns at a falling edge; valid stays high across back-to-back words.
    task automatic push_pair(input rgb2yuv_pkg::t_rgb_pair p);
        while (!steady_flow && $urandom_range(99) < 32) begin
            pair_if.valid = 1'b0;
            pair_if.data  = 48'({$urandom, $urandom});
            @(negedge i_clk);
        end
        pair_if.valid = 1'b1;
        pair_if.data  = p;
        do @(posedge i_clk); while (!pair_if.ready);
        ledger.note_pair(p);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        pair_if.valid = 1'b0;
        while (ledger.owed_words.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        rgb2yuv_pkg::t_rgb_pair corner_pairs[$];

        pair_if.valid = 1'b0;
        pair_if.data  = '0;

        corner_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        corner_pairs.push_back(make_pair(255, 255, 255, 255, 255, 255));
        corner_pairs.push_back(make_pair(255, 0, 0, 0, 255, 0));
        corner_pairs.push_back(make_pair(0, 255, 0, 255, 0, 0));
        corner_pairs.push_back(make_pair(0, 0, 255, 255, 0, 0));
        corner_pairs.push_back(make_pair(255, 0, 255, 0, 0, 255));
        corner_pairs.push_back(make_pair(0, 0, 255, 0, 0, 255));
        corner_pairs.push_back(make_pair(255, 255, 0, 255, 255, 0));
        corner_pairs.push_back(make_pair(0, 255, 255, 255, 0, 255));
        corner_pairs.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
        corner_pairs.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        // gray first pixel: chroma follows the second
        corner_pairs.push_back(make_pair(128, 128, 128, 17, 200, 3));
        corner_pairs.push_back(make_pair(0, 0, 0, 255, 254, 0));
        // red equal to green in both pixels: chroma stays with the first
        corner_pairs.push_back(make_pair(128, 128, 128, 17, 17, 200));
        corner_pairs.push_back(make_pair(60, 60, 255, 200, 200, 0));
        corner_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
        corner_pairs.push_back(make_pair(100, 101, 50, 30, 40, 50));
        corner_pairs.push_back(make_pair(255, 254, 0, 0, 1, 255));

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (corner_pairs[n]) push_pair(corner_pairs[n]);
        wait_for_drain();

        for (int n = 0; n < 1200; n++) begin
            steady_flow = (n >= 400 && n < 700);
            if (n == 850) wait_for_drain();
            push_pair(random_pair());
        end
        steady_flow   = 1'b0;
        pair_if.valid = 1'b0;

        while (ledger.owed_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (ledger.bad_words == 0 && ledger.owed_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
